>>> rtl/md5_pkg.sv
// Shared types, constants and lookup functions for the MD5 digest core.
// Depends on nothing; md5_round and the digest core import it.
`default_nettype none

package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam int unsigned COUNT_W  = 61;
  localparam int unsigned WORDS    = 16;
  localparam int unsigned ROUND_W  = 6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Additive constant of each of the 64 steps.
  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotation amount of each step, repeating every four steps per group.
  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    logic [4:0] s;
    unique case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by each step.
  function automatic logic [3:0] word_index(input logic [5:0] idx);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = idx[3:0];
    unique case (idx[5:4])
      2'd0:    g = i4;
      2'd1:    g = i4 * 4'd5 + 4'd1;
      2'd2:    g = i4 * 4'd3 + 4'd5;
      2'd3:    g = i4 * 4'd7;
      default: g = i4;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/md5_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the message block as sixteen little-endian words; no package needed.
`default_nettype none

module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/md5_round.sv
// One MD5 step: boolean function, rotation and the final add into B.
// Uses rot_amount from md5_pkg; the caller supplies the pre-added A + K + W sum.
`default_nettype none

module md5_round (
  input  wire logic [5:0]  step,
  input  wire logic [31:0] pre,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  output logic      [31:0] b_new
);

  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] tmp;
  logic [63:0] dbl;

  always_comb begin
    unique case (step[5:4])
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = '0;
    endcase
    tmp   = pre + f;
    dbl   = {tmp, tmp} << rot_amount(step);
    b_new = b + dbl[63:32];
  end

endmodule

`default_nettype wire

>>> rtl/md5_message_digest_core.sv
// MD5 digest core: byte intake, padding sequencer and iterative compression.
// Depends on md5_pkg, md5_ram and md5_round.
//
//   channel | valid        | stall        | payload          | direction
//   msg     | msg_valid    | msg_stall    | msg (msg_t)      | in
//   digest  | digest_valid | digest_stall | digest(digest_t) | out
//
// A byte that does not fill a block is taken in the idle state. A full block runs
// through the single shared step unit (one step per cycle behind the registered word
// fetch and pre-add) and then folds into the chaining words.
// Padding writes one word per cycle up to word 15, then compresses; a message that
// leaves 56 to 63 bytes in its last block costs a second padding block.
// Reset is synchronous and restores the initial chaining words and zero count.
// The digest sits in an output register; only a new digest waits on digest_stall.
`default_nettype none

module md5_message_digest_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            msg_valid,
  output logic                 msg_stall,
  input  wire md5_pkg::msg_t   msg,
  output logic                 digest_valid,
  input  wire logic            digest_stall,
  output md5_pkg::digest_t     digest
);

  import md5_pkg::*;

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_after;
  logic [23:0]        partial;
  logic [6:0]         cyc;
  logic [3:0]         wp;
  logic               second;
  logic               padding;
  logic               last_pending;

  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] pre;
  logic [31:0] b_new;

  logic        accept;
  logic        extra;
  logic        len_block;
  logic        emit_go;
  logic [5:0]  pre_step;
  logic [5:0]  run_step;
  logic [31:0] pad_word;
  logic [31:0] pad_value;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  assign msg_stall   = (state != ST_IDLE);
  assign accept      = msg_valid && !msg_stall;
  assign count_inc   = count + COUNT_W'(1);
  assign count_after = msg.has_byte ? count_inc : count;
  assign extra       = (count[5:3] == 3'b111);
  assign len_block   = second || !extra;
  assign emit_go     = !digest_valid || !digest_stall;
  assign pre_step    = 6'(cyc - 7'd1);
  assign run_step    = 6'(cyc - 7'd2);

  // First padding word: buffered bytes of the open word, then the 0x80 marker.
  always_comb begin
    unique case (count[1:0])
      2'd0:    pad_word = {24'h0, PAD_BYTE};
      2'd1:    pad_word = {16'h0, PAD_BYTE, partial[7:0]};
      2'd2:    pad_word = {8'h0, PAD_BYTE, partial[15:0]};
      2'd3:    pad_word = {PAD_BYTE, partial[23:0]};
      default: pad_word = '0;
    endcase
  end

  always_comb begin
    priority if (!second && wp == count[5:2]) begin
      pad_value = pad_word;
    end else if (len_block && wp == 4'd14) begin
      pad_value = {count[28:0], 3'b000};
    end else if (len_block && wp == 4'd15) begin
      pad_value = count[60:29];
    end else begin
      pad_value = '0;
    end
  end

  always_comb begin
    if (state == ST_PAD) begin
      ram_we    = 1'b1;
      ram_waddr = wp;
      ram_wdata = pad_value;
    end else begin
      ram_we    = accept && msg.has_byte && (count[1:0] == 2'd3);
      ram_waddr = count[5:2];
      ram_wdata = {msg.data_byte, partial};
    end
  end

  md5_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (word_index(cyc[5:0])),
    .rdata (ram_rdata)
  );

  md5_round u_round (
    .step  (run_step),
    .pre   (pre),
    .b     (wb),
    .c     (wc),
    .d     (wd),
    .b_new (b_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (msg.has_byte && count_inc[5:0] == 6'd0) begin
            state_next = ST_ROUND;
          end else if (msg.is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (cyc == 7'd65) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (padding) begin
          state_next = (!second && extra) ? ST_PAD : ST_EMIT;
        end else if (last_pending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (wp == 4'd15) begin
          state_next = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control and chaining state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      chain_a      <= INIT_A;
      chain_b      <= INIT_B;
      chain_c      <= INIT_C;
      chain_d      <= INIT_D;
      cyc          <= '0;
      wp           <= '0;
      second       <= 1'b0;
      padding      <= 1'b0;
      last_pending <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      // In the emit state a taken digest is replaced by the new one below.
      if (digest_valid && !digest_stall && state != ST_EMIT) begin
        digest_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count        <= count_after;
            last_pending <= msg.is_last;
            cyc          <= '0;
            if (msg.is_last && !(msg.has_byte && count_inc[5:0] == 6'd0)) begin
              padding <= 1'b1;
              second  <= 1'b0;
              wp      <= count_after[5:2];
            end
          end
        end
        ST_ROUND: begin
          cyc <= cyc + 7'd1;
        end
        ST_FOLD: begin
          chain_a <= chain_a + wa;
          chain_b <= chain_b + wb;
          chain_c <= chain_c + wc;
          chain_d <= chain_d + wd;
          cyc     <= '0;
          if (padding) begin
            second <= 1'b1;
            wp     <= '0;
          end else if (last_pending) begin
            padding <= 1'b1;
            second  <= 1'b0;
            wp      <= count[5:2];
          end
        end
        ST_PAD: begin
          wp <= wp + 4'd1;
        end
        ST_EMIT: begin
          if (emit_go) begin
            digest_valid <= 1'b1;
            count        <= '0;
            chain_a      <= INIT_A;
            chain_b      <= INIT_B;
            chain_c      <= INIT_C;
            chain_d      <= INIT_D;
            padding      <= 1'b0;
            second       <= 1'b0;
            last_pending <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (state != ST_ROUND && state_next == ST_ROUND) begin
      wa <= chain_a;
      wb <= chain_b;
      wc <= chain_c;
      wd <= chain_d;
    end else if (state == ST_ROUND && cyc >= 7'd2) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= b_new;
    end
    // The A of the next step is the current D, except for the first step.
    if (state == ST_ROUND && cyc >= 7'd1 && cyc <= 7'd64) begin
      pre <= ((pre_step == 6'd0) ? wa : wd) + round_const(pre_step) + ram_rdata;
    end
    if (state == ST_IDLE && accept && msg.has_byte) begin
      unique case (count[1:0])
        2'd0:    partial[7:0]   <= msg.data_byte;
        2'd1:    partial[15:8]  <= msg.data_byte;
        2'd2:    partial[23:16] <= msg.data_byte;
        default: begin
        end
      endcase
    end
    if (state == ST_EMIT && emit_go) begin
      digest.digest_word0 <= chain_a;
      digest.digest_word1 <= chain_b;
      digest.digest_word2 <= chain_c;
      digest.digest_word3 <= chain_d;
    end
  end

`ifndef SYNTHESIS
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (cyc <= 7'd65))
    else $error("step counter ran past the last step");

  a_pad_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD && !second) |-> (wp >= count[5:2]))
    else $error("padding wrote below the message end");

  a_emit_reinit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && emit_go) |=>
      (digest_valid && count == '0 && chain_a == INIT_A && state == ST_IDLE))
    else $error("digest transaction did not restart the chaining state");

  a_block_boundary: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD && !padding) |-> (count[5:0] == 6'd0))
    else $error("a data block was compressed before it was full");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for md5_message_digest_core: directed table, then random messages.
// Depends on md5_pkg for the transaction types and initial chaining words.
// The digest of every accepted message end is predicted here, or taken from the directed table, and checked.
`default_nettype none

module tb_top;
  import md5_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES = 800;

  localparam logic [31:0] STEP_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned STEP_ROT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam digest_t NO_DIGEST    = '0;
  localparam digest_t EMPTY_DIGEST = '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
  localparam digest_t A_DIGEST     = '{32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769};
  localparam digest_t ABC_DIGEST   = '{32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};

  typedef struct packed {
    msg_t    item;
    logic    known;
    digest_t want;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 14;

  // Typed digests are the well-known ones for "", "a" and "abc".
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h61, 1'b1, 1'b1}, 1'b1, A_DIGEST},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h80, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, NO_DIGEST},
    '{'{8'hff, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, NO_DIGEST},
    '{'{8'ha5, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h5a, 1'b0, 1'b1}, 1'b0, NO_DIGEST}
  };

  localparam int unsigned EDGE_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    msg_valid = 1'b0;
  logic    msg_stall;
  msg_t    msg = '0;
  logic    digest_valid;
  logic    digest_stall = 1'b0;
  digest_t digest;

  // Flags that travel with the payload on the message channel.
  logic    row_known = 1'b0;
  digest_t row_want = '0;

  // Predictor state.
  logic [31:0] hash_a, hash_b, hash_c, hash_d;
  logic [60:0] msg_bytes;
  logic [7:0]  blk [64];

  digest_t     pending_digests [$];
  int unsigned mismatches = 0;
  int unsigned digests_taken = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_quiet = 0;

  md5_message_digest_core DUT (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  always #5 clk = ~clk;

  function automatic void restart_hash();
    hash_a = INIT_A;
    hash_b = INIT_B;
    hash_c = INIT_C;
    hash_d = INIT_D;
    msg_bytes = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int          i, g, s;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    end
    a = hash_a;
    b = hash_b;
    c = hash_c;
    d = hash_d;
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = STEP_ROT[(i / 16) * 4 + i % 4];
      t = a + f + w[g] + STEP_K[i];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    hash_a += a;
    hash_b += b;
    hash_c += c;
    hash_d += d;
  endfunction

  // Applies one accepted transaction; returns 1 when it closes a message.
  function automatic bit absorb_item(input msg_t m, output digest_t result);
    int          used;
    int          j;
    logic [63:0] bit_len;
    result = '0;
    if (m.has_byte) begin
      blk[msg_bytes[5:0]] = m.data_byte;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) begin
        fold_block();
      end
    end
    if (!m.is_last) begin
      return 1'b0;
    end
    used = int'(msg_bytes[5:0]);
    blk[used] = PAD_BYTE;
    used++;
    // Not enough room left for the length: it goes into an extra block.
    if (used > 56) begin
      for (j = used; j < 64; j++) blk[j] = 8'h00;
      fold_block();
      used = 0;
    end
    for (j = used; j < 56; j++) blk[j] = 8'h00;
    bit_len = {msg_bytes, 3'b000};
    for (j = 0; j < 8; j++) blk[56 + j] = bit_len[8*j +: 8];
    fold_block();
    result = '{hash_a, hash_b, hash_c, hash_d};
    restart_hash();
    return 1'b1;
  endfunction

  task automatic report_word(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("digest %0d %s: expected %08h, got %08h", digests_taken, field, want, got);
      end
    end
  endtask

  task automatic send_item(input msg_t m, input logic known, input digest_t want);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (send_quiet != 0) begin
      send_quiet--;
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 92) begin
      gap = $urandom_range(10, 40);
    end else begin
      gap = 0;
      send_quiet = $urandom_range(30, 150);
    end
    @(negedge clk);
    if (gap != 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    row_known <= known;
    row_want <= want;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    if (m.has_byte || m.is_last) begin
      items_sent++;
    end
  endtask

  // One message of random content; the end may ride on the last byte.
  task automatic send_message(input int unsigned len);
    msg_t        m;
    logic        merge;
    int unsigned k;
    merge = (len != 0) && $urandom_range(0, 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        m = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, is_last: 1'b0};
        send_item(m, 1'b0, NO_DIGEST);
      end
      m = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b1,
            is_last: merge && (k == len - 1)};
      send_item(m, 1'b0, NO_DIGEST);
    end
    if (!merge) begin
      m = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, is_last: 1'b1};
      send_item(m, 1'b0, NO_DIGEST);
    end
  endtask

  // Prediction on accepted messages and checking of accepted digests.
  always @(posedge clk) begin
    digest_t want;
    digest_t predicted;
    if (!rst) begin
      if (digest_valid && !digest_stall) begin
        if (pending_digests.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected digest %08h %08h %08h %08h", digest.digest_word0,
                     digest.digest_word1, digest.digest_word2, digest.digest_word3);
          end
        end else begin
          want = pending_digests.pop_front();
          report_word("word0", want.digest_word0, digest.digest_word0);
          report_word("word1", want.digest_word1, digest.digest_word1);
          report_word("word2", want.digest_word2, digest.digest_word2);
          report_word("word3", want.digest_word3, digest.digest_word3);
        end
        digests_taken++;
      end
      if (msg_valid && !msg_stall) begin
        if (absorb_item(msg, predicted)) begin
          pending_digests.push_back(row_known ? row_want : predicted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Digest side: random stall, quiet stretches, and one long hold-off.
  initial begin
    int unsigned r;
    int unsigned hold;
    int unsigned quiet;
    bit          held_long;
    quiet = 0;
    held_long = 1'b0;
    forever begin
      @(negedge clk);
      hold = 1;
      r = $urandom_range(0, 99);
      if (!held_long && digests_taken >= 12) begin
        held_long = 1'b1;
        digest_stall <= 1'b1;
        hold = HOLD_CYCLES;
      end else if (quiet != 0) begin
        quiet--;
        digest_stall <= 1'b0;
      end else if (r < 55) begin
        digest_stall <= 1'b0;
      end else if (r < 85) begin
        digest_stall <= 1'b1;
        hold = $urandom_range(1, 3);
      end else if (r < 91) begin
        digest_stall <= 1'b1;
        hold = $urandom_range(20, 60);
      end else begin
        digest_stall <= 1'b0;
        quiet = $urandom_range(50, 200);
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin
    int unsigned n;
    restart_hash();
    for (n = 0; n < 64; n++) blk[n] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIR_ROWS; n++) begin
      send_item(DIRECTED[n].item, DIRECTED[n].known, DIRECTED[n].want);
    end

    // Lengths around the point where the length field spills into an extra block.
    for (n = 0; n < 9; n++) begin
      send_message(EDGE_LENS[n]);
    end
    while (items_sent < ITEM_TARGET) begin
      n = $urandom_range(0, 99);
      if (n < 70) begin
        send_message($urandom_range(0, 20));
      end else if (n < 85) begin
        send_message(EDGE_LENS[$urandom_range(0, 8)]);
      end else begin
        send_message($urandom_range(21, 200));
      end
    end
    @(negedge clk);
    msg_valid <= 1'b0;

    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_digests.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
